// ===== hw/rtl/tts_pkg.sv =====
// tts_pkg: shared types, constants and tag tables for the think tag stream splitter
// no dependencies; imported by think_tag_stream_splitter_top and tb_think_tag_stream_splitter_top
`default_nettype none

package tts_pkg;

	localparam int NUM_CHANNELS = 4;
	localparam int CH_W         = 2;
	localparam int BYTE_W       = 8;
	localparam int CNT_W        = 3;
	localparam int DATA_W       = 16;

	localparam logic OP_TEXT  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic MODE_NORMAL    = 1'b0;
	localparam logic MODE_REASONING = 1'b1;

	localparam logic [CNT_W-1:0] OPEN_LEN_M1  = 3'd6;
	localparam logic [CNT_W-1:0] CLOSE_LEN_M1 = 3'd7;

	localparam logic [BYTE_W-1:0] CHAR_LT = 8'h3c;

	typedef struct packed {
		logic             mode;
		logic [CNT_W-1:0] cnt;
	} chan_state_t;

	// byte idx of "<think>" (mode 0) or "</think>" (mode 1)
	function automatic logic [BYTE_W-1:0] tag_byte(input logic mode,
		input logic [CNT_W-1:0] idx);
		logic [BYTE_W-1:0] b;
		b = CHAR_LT;
		if (mode == MODE_REASONING) begin
			case (idx)
				3'd0:    b = 8'h3c;
				3'd1:    b = 8'h2f;
				3'd2:    b = 8'h74;
				3'd3:    b = 8'h68;
				3'd4:    b = 8'h69;
				3'd5:    b = 8'h6e;
				3'd6:    b = 8'h6b;
				default: b = 8'h3e;
			endcase
		end else begin
			case (idx)
				3'd0:    b = 8'h3c;
				3'd1:    b = 8'h74;
				3'd2:    b = 8'h68;
				3'd3:    b = 8'h69;
				3'd4:    b = 8'h6e;
				3'd5:    b = 8'h6b;
				default: b = 8'h3e;
			endcase
		end
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/think_tag_stream_splitter_top.sv =====
// think_tag_stream_splitter_top: per-channel think tag splitter over a state memory
// depends on tts_pkg
//
// usage:
//  s_axis carries one transaction per text byte or flush request; tdata holds
//  the channel and the byte, tuser the opcode (text or flush).
//  m_axis carries one transaction per emitted byte; tdata holds channel and
//  byte, tuser is high for reasoning text, tlast marks the final byte caused
//  by one input transaction. an input that only extends or completes a tag,
//  or a flush with nothing held, produces no output transaction.
//  the per-channel state memory is read as an input is accepted; the update
//  stage computes and writes back the new state and loads the output register.
//  throughput: one input per cycle while each input yields at most one byte
//  and m_axis_tready stays high; an input that yields n bytes (up to 8) holds
//  the output register until its last byte is taken; the byte count sets the rate.
//  back-to-back inputs on one channel are forwarded past the memory.
//  reset clears all channel modes to normal and all match counts to zero
//  at once through per-entry valid bits. when m_axis_tready is low the
//  output register holds, then the update stage, then s_axis_tready drops.
`default_nettype none

module think_tag_stream_splitter_top (
	input  wire  logic                       clk,
	input  wire  logic                       arst_n,
	input  wire  logic                       s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire  logic [tts_pkg::DATA_W-1:0] s_axis_tdata,  // channel[1:0], text_byte[9:2]
	input  wire  logic                       s_axis_tuser,  // opcode[0]
	output logic                             m_axis_tvalid,
	input  wire  logic                       m_axis_tready,
	output logic [tts_pkg::DATA_W-1:0]       m_axis_tdata,  // out_channel[1:0], out_byte[9:2]
	output logic                             m_axis_tuser,  // to_reasoning[0]
	output logic                             m_axis_tlast
);
	import tts_pkg::*;

	// input unpack
	logic [CH_W-1:0]   in_ch;
	logic [BYTE_W-1:0] in_byte;
	logic              in_acc;

	assign in_ch   = s_axis_tdata[CH_W-1:0];
	assign in_byte = s_axis_tdata[CH_W+BYTE_W-1:CH_W];
	assign in_acc  = s_axis_tvalid && s_axis_tready;

	// state memory
	chan_state_t               state_mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0]   st_valid_q;
	chan_state_t               rdata_s1;
	logic                      rvalid_s1;

	// write port
	logic                      wr_en;
	logic [CH_W-1:0]           wr_addr;
	chan_state_t               wr_data;

	// stage 1
	logic                      valid_s1;
	logic [CH_W-1:0]           ch_s1;
	logic                      op_s1;
	logic [BYTE_W-1:0]         byte_s1;
	logic                      fwd_hit_s1;
	chan_state_t               fwd_data_s1;

	// stage 2 (output register)
	logic                      valid_s2;
	logic [CH_W-1:0]           ch_s2;
	logic                      mode_s2;
	logic [CNT_W-1:0]          cnt_s2;
	logic                      emitb_s2;
	logic [BYTE_W-1:0]         byte_s2;
	logic [CNT_W-1:0]          idx_s2;

	// stage 1 logic
	chan_state_t               cur_st;
	logic [CNT_W-1:0]          cnt_c;
	logic [CNT_W-1:0]          len_m1;
	logic                      ch_ok;
	logic                      match;
	logic                      full;
	logic                      emitb;
	logic                      no_out;
	chan_state_t               nxt_st;
	logic                      s2_free;
	logic                      s1_adv;
	logic                      out_last;
	logic                      out_acc;

	always_comb begin
		cur_st = '0;
		if (fwd_hit_s1) begin
			cur_st = fwd_data_s1;
		end else if (rvalid_s1) begin
			cur_st = rdata_s1;
		end
		len_m1 = (cur_st.mode == MODE_REASONING) ? CLOSE_LEN_M1 : OPEN_LEN_M1;
		cnt_c  = (cur_st.cnt > len_m1) ? len_m1 : cur_st.cnt;
		ch_ok  = ({1'b0, ch_s1} < (CH_W+1)'(NUM_CHANNELS));
		match  = (op_s1 == OP_TEXT) && (byte_s1 == tag_byte(cur_st.mode, cnt_c));
		full   = match && (cnt_c == len_m1);
		emitb  = !match && (op_s1 == OP_TEXT) && (byte_s1 != CHAR_LT);
		no_out = !ch_ok || match || ((cnt_c == '0) && !emitb);
		nxt_st.mode = cur_st.mode;
		nxt_st.cnt  = '0;
		if (full) begin
			nxt_st.mode = ~cur_st.mode;
		end else if (match) begin
			nxt_st.cnt = cnt_c + CNT_W'(1);
		end else if ((op_s1 == OP_TEXT) && (byte_s1 == CHAR_LT)) begin
			nxt_st.cnt = CNT_W'(1);
		end
	end

	assign out_last = emitb_s2 ? (idx_s2 == cnt_s2)
		: ({1'b0, idx_s2} + 4'd1 == {1'b0, cnt_s2});
	assign out_acc  = valid_s2 && m_axis_tready;
	assign s2_free  = !valid_s2 || (m_axis_tready && out_last);
	assign s1_adv   = valid_s1 && (no_out || s2_free);
	assign s_axis_tready = !valid_s1 || s1_adv;

	assign wr_en   = s1_adv && ch_ok;
	assign wr_addr = ch_s1;
	assign wr_data = nxt_st;

	// memory, read and write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			state_mem[wr_addr] <= wr_data;
		end
		if (in_acc) begin
			rdata_s1    <= state_mem[in_ch];
			ch_s1       <= in_ch;
			op_s1       <= s_axis_tuser;
			byte_s1     <= in_byte;
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_valid_q <= '0;
			valid_s1   <= 1'b0;
			rvalid_s1  <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				st_valid_q[wr_addr] <= 1'b1;
			end
			if (in_acc) begin
				valid_s1   <= 1'b1;
				rvalid_s1  <= st_valid_q[in_ch];
				fwd_hit_s1 <= wr_en && (wr_addr == in_ch);
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= '0;
		end else begin
			if (s1_adv && !no_out) begin
				valid_s2 <= 1'b1;
				idx_s2   <= '0;
			end else if (out_acc && out_last) begin
				valid_s2 <= 1'b0;
			end else if (out_acc) begin
				idx_s2 <= idx_s2 + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && !no_out) begin
			ch_s2    <= ch_s1;
			mode_s2  <= cur_st.mode;
			cnt_s2   <= match ? '0 : cnt_c;
			emitb_s2 <= emitb;
			byte_s2  <= byte_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(DATA_W-CH_W-BYTE_W){1'b0}},
		((idx_s2 < cnt_s2) ? tag_byte(mode_s2, idx_s2) : byte_s2), ch_s2};
	assign m_axis_tuser  = mode_s2;
	assign m_axis_tlast  = out_last;

	// checks
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_s2 <= cnt_s2))
		else $error("emit index beyond held prefix");

	a_s2_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((cnt_s2 != '0) || emitb_s2))
		else $error("output register holds a transaction with no bytes");

	a_open_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !((wr_data.mode == MODE_NORMAL) && (wr_data.cnt == CLOSE_LEN_M1)))
		else $error("open tag match count reached tag length");

	a_load_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && !no_out) |=> (valid_s2 && (idx_s2 == '0)))
		else $error("output register load lost");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(ch_s1) && $stable(byte_s1)))
		else $error("update stage changed while stalled");

endmodule

`default_nettype wire

// ===== sim/tb_think_tag_stream_splitter_top.sv =====
// tb_think_tag_stream_splitter_top: self-checking testbench for the think tag splitter,
// a directed table followed by random tag traffic, checked against a local predictor
// depends on tts_pkg and think_tag_stream_splitter_top
`timescale 1ns / 1ps

module tb_think_tag_stream_splitter_top;
	import tts_pkg::*;

	localparam int TOTAL_ITEMS = 325;
	localparam int HOLD_AT     = 110;
	localparam int DRAIN_AT    = 170;
	localparam int CALM_AT     = 280;
	localparam int HOLD_CYCLES = 96;
	localparam int TAIL_CYCLES = 20;
	localparam int LIMIT       = 200000;

	localparam logic [55:0] OPEN_STR  = "<think>";
	localparam logic [63:0] CLOSE_STR = "</think>";

	typedef struct packed {
		logic [CH_W-1:0]   ch;
		logic [BYTE_W-1:0] data;
		logic              reasoning;
		logic              last;
	} emit_t;

	typedef struct packed {
		logic [CH_W-1:0]   ch;
		logic              op;
		logic [BYTE_W-1:0] data;
	} req_t;

	typedef struct packed {
		req_t              req;
		logic              typed;
		logic              t_one;
		logic [BYTE_W-1:0] t_data;
		logic              t_reason;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata;  // channel[1:0], text_byte[9:2]
	logic              s_axis_tuser;  // opcode[0]
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [DATA_W-1:0] m_axis_tdata;  // out_channel[1:0], out_byte[9:2]
	logic              m_axis_tuser;  // to_reasoning[0]
	logic              m_axis_tlast;

	emit_t             emit_q[$];
	emit_t             pred_q[$];
	dir_row_t          dir_q[$];
	logic              chan_mode [NUM_CHANNELS];
	logic [CNT_W-1:0]  chan_held [NUM_CHANNELS];
	int                errors;
	int                sent;
	int                gap_pct;
	int                stall_pct;
	bit                calm;
	bit                hold_now;

	think_tag_stream_splitter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [BYTE_W-1:0] tag_char(input logic mode, input int idx);
		if (mode == MODE_REASONING)
			return CLOSE_STR[8*(7-idx) +: 8];
		return OPEN_STR[8*(6-idx) +: 8];
	endfunction

	function automatic emit_t make_emit(input logic [CH_W-1:0] ch,
		input logic [BYTE_W-1:0] data, input logic reasoning, input logic last);
		emit_t e;
		e.ch        = ch;
		e.data      = data;
		e.reasoning = reasoning;
		e.last      = last;
		return e;
	endfunction

	function automatic req_t make_req(input logic [CH_W-1:0] ch, input logic op,
		input logic [BYTE_W-1:0] data);
		req_t r;
		r.ch   = ch;
		r.op   = op;
		r.data = data;
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] rand_text();
		if ($urandom_range(0, 1))
			return BYTE_W'($urandom_range(0, 255));
		return tag_char(MODE_REASONING, $urandom_range(0, 7));
	endfunction

	// routes one transaction, fills pred_q with the bytes it emits
	function automatic void predict_split(input req_t r);
		logic  mode;
		int    len;
		int    held;
		mode = chan_mode[r.ch];
		len  = (mode == MODE_REASONING) ? 8 : 7;
		held = chan_held[r.ch];
		if (held >= len)
			held = len - 1;
		pred_q.delete();
		if (r.op == OP_TEXT && r.data == tag_char(mode, held)) begin
			if (held + 1 == len) begin
				chan_mode[r.ch] = ~mode;
				chan_held[r.ch] = '0;
			end else begin
				chan_held[r.ch] = CNT_W'(held + 1);
			end
			return;
		end
		for (int i = 0; i < held; i++)
			pred_q.push_back(make_emit(r.ch, tag_char(mode, i), mode, 1'b0));
		if (r.op == OP_TEXT && r.data == CHAR_LT) begin
			chan_held[r.ch] = 3'd1;
		end else begin
			if (r.op == OP_TEXT)
				pred_q.push_back(make_emit(r.ch, r.data, mode, 1'b0));
			chan_held[r.ch] = '0;
		end
		if (pred_q.size() > 0)
			pred_q[pred_q.size() - 1].last = 1'b1;
	endfunction

	task automatic send_item(input req_t r, input logic typed, input logic t_one,
		input logic [BYTE_W-1:0] t_data, input logic t_reason);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < gap_pct)
			gap = $urandom_range(1, 8);
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(DATA_W-CH_W-BYTE_W){1'b0}}, r.data, r.ch};
		s_axis_tuser  <= r.op;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
		predict_split(r);
		if (typed) begin
			if (t_one)
				emit_q.push_back(make_emit(r.ch, t_data, t_reason, 1'b1));
		end else begin
			foreach (pred_q[i])
				emit_q.push_back(pred_q[i]);
		end
	endtask

	task automatic drain_outputs();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (emit_q.size() > 0)
			@(posedge clk);
	endtask

	task automatic add_row(input logic [CH_W-1:0] ch, input logic op,
		input logic [BYTE_W-1:0] data);
		dir_row_t d;
		d          = '0;
		d.req      = make_req(ch, op, data);
		dir_q.push_back(d);
	endtask

	task automatic add_typed(input logic [CH_W-1:0] ch, input logic op,
		input logic [BYTE_W-1:0] data, input logic t_one,
		input logic [BYTE_W-1:0] t_data, input logic t_reason);
		dir_row_t d;
		d.req      = make_req(ch, op, data);
		d.typed    = 1'b1;
		d.t_one    = t_one;
		d.t_data   = t_data;
		d.t_reason = t_reason;
		dir_q.push_back(d);
	endtask

	task automatic add_string(input logic [CH_W-1:0] ch, input logic mode, input int n);
		for (int i = 0; i < n; i++)
			add_row(ch, OP_TEXT, tag_char(mode, i));
	endtask

	// output side: random stall bursts plus one long hold-off
	initial begin
		int stall_left;
		int hold_left;
		bit hold_done;
		stall_left    = 0;
		hold_left     = 0;
		hold_done     = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_now && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!calm && $urandom_range(0, 99) < stall_pct)
					stall_left = $urandom_range(1, 8);
			end
		end
	end

	always @(posedge clk) begin : check_output
		emit_t got;
		emit_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = make_emit(m_axis_tdata[CH_W-1:0],
				m_axis_tdata[CH_W+BYTE_W-1:CH_W], m_axis_tuser, m_axis_tlast);
			if (emit_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction: expected none, ", $time,
					"actual ch=%0d byte=%h rsn=%b last=%b",
					got.ch, got.data, got.reasoning, got.last);
			end else begin
				want = emit_q.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: mismatch: expected ch=%0d byte=%h rsn=%b last=%b, ",
						$time, want.ch, want.data, want.reasoning, want.last,
						"actual ch=%0d byte=%h rsn=%b last=%b",
						got.ch, got.data, got.reasoning, got.last);
				end
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		req_t             burst[$];
		req_t             r;
		logic             mode;
		logic [CH_W-1:0]  ch;
		int               len;
		int               k;
		int               kind;
		bit               drained;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_TEXT;
		errors        = 0;
		sent          = 0;
		gap_pct       = 15;
		stall_pct     = 15;
		calm          = 1'b0;
		hold_now      = 1'b0;
		drained       = 1'b0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			chan_mode[i] = MODE_NORMAL;
			chan_held[i] = '0;
		end

		// after reset channels 0 to 2 route text to content and a flush on channel 3 emits nothing
		add_typed(2'd0, OP_TEXT, 8'h41, 1'b1, 8'h41, MODE_NORMAL);
		add_typed(2'd1, OP_TEXT, 8'h00, 1'b1, 8'h00, MODE_NORMAL);
		add_typed(2'd2, OP_TEXT, 8'hff, 1'b1, 8'hff, MODE_NORMAL);
		add_typed(2'd3, OP_FLUSH, 8'h00, 1'b0, 8'h00, MODE_NORMAL);
		// open tag, reasoning byte, full close prefix broken by a plain byte
		add_string(2'd1, MODE_NORMAL, 7);
		add_row(2'd1, OP_TEXT, 8'h72);
		add_string(2'd1, MODE_REASONING, 7);
		add_row(2'd1, OP_TEXT, 8'h5a);
		// prefix broken by a new tag start, then flushed
		add_string(2'd2, MODE_NORMAL, 2);
		add_row(2'd2, OP_TEXT, CHAR_LT);
		add_row(2'd2, OP_FLUSH, 8'h5a);
		add_typed(2'd1, OP_FLUSH, 8'hff, 1'b0, 8'h00, MODE_REASONING);

		wait (arst_n === 1'b1);
		foreach (dir_q[i])
			send_item(dir_q[i].req, dir_q[i].typed, dir_q[i].t_one,
				dir_q[i].t_data, dir_q[i].t_reason);
		drain_outputs();

		while (sent < TOTAL_ITEMS) begin
			ch   = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
			mode = chan_mode[ch];
			len  = (mode == MODE_REASONING) ? 8 : 7;
			kind = $urandom_range(0, 9);
			burst.delete();
			if (kind < 4) begin
				for (int i = 0; i < len; i++)
					burst.push_back(make_req(ch, OP_TEXT, tag_char(mode, i)));
				repeat ($urandom_range(0, 3))
					burst.push_back(make_req(ch, OP_TEXT, rand_text()));
			end else if (kind < 7) begin
				k = $urandom_range(1, len - 1);
				for (int i = 0; i < k; i++)
					burst.push_back(make_req(ch, OP_TEXT, tag_char(mode, i)));
				case ($urandom_range(0, 3))
					0: burst.push_back(make_req(ch, OP_TEXT, rand_text()));
					1: burst.push_back(make_req(ch, OP_TEXT, CHAR_LT));
					2: burst.push_back(make_req(ch, OP_FLUSH,
						BYTE_W'($urandom_range(0, 255))));
					default: ;
				endcase
			end else if (kind < 9) begin
				repeat ($urandom_range(1, 4))
					burst.push_back(make_req(ch, OP_TEXT, rand_text()));
			end else begin
				burst.push_back(make_req(ch, OP_FLUSH, BYTE_W'($urandom_range(0, 255))));
			end

			foreach (burst[i]) begin
				if (sent >= HOLD_AT)
					hold_now = 1'b1;
				if (sent >= CALM_AT)
					calm = 1'b1;
				if ($urandom_range(0, 7) == 0) begin
					r = make_req(CH_W'((ch + $urandom_range(1, 3)) % NUM_CHANNELS),
						($urandom_range(0, 4) == 0) ? OP_FLUSH : OP_TEXT, rand_text());
					send_item(r, 1'b0, 1'b0, '0, 1'b0);
				end
				send_item(burst[i], 1'b0, 1'b0, '0, 1'b0);
			end

			if (sent >= DRAIN_AT && !drained) begin
				drained = 1'b1;
				drain_outputs();
			end
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 10;
					default: gap_pct = 35;
				endcase
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 10;
					default: stall_pct = 35;
				endcase
			end
		end

		drain_outputs();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

endmodule
